/* design/tbmpc_pkg.sv */
// ----------------------------------------------------------------------------
// tbmpc_pkg
// Shared types, constants and MD5 tables for the body pad cipher.
// ----------------------------------------------------------------------------
package tbmpc_pkg;

	localparam int MAX_KEY_BYTES = 32;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_LEN = 3'd0;
	localparam logic [2:0] REG_KEY_0   = 3'd1;
	localparam logic [2:0] REG_KEY_1   = 3'd2;
	localparam logic [2:0] REG_KEY_2   = 3'd3;
	localparam logic [2:0] REG_KEY_3   = 3'd4;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage

/* design/tacacs_body_md5_pad_cipher.sv */
// ----------------------------------------------------------------------------
// tacacs_body_md5_pad_cipher
// XORs body bytes with the MD5 pseudo pad; a new pad at each first byte and every 16 bytes.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_axis   in   tvalid/tready        tdata, tuser, tlast
// m_axis   out  tvalid/tready        tdata, tlast
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A byte that needs a fresh pad runs the 64 MD5 rounds through one shared
// round unit, then adds the digest and loads the output register, then
// waits for the output transaction and returns to idle. Other bytes skip
// the rounds. Reset clears key, pad chain and header latch. A stalled
// m_axis holds the result and the block takes no new byte until it leaves.
// ----------------------------------------------------------------------------
module tacacs_body_md5_pad_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // session_id[31:0], version, seq_no, body_byte
	input  logic        s_axis_tuser,  // first_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // result_byte
	output logic        m_axis_tlast,  // result_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	tbmpc_pkg::state_t state_q;
	logic [5:0]   key_len_q;
	logic [255:0] key_q;
	logic [127:0] pad_q;
	logic [3:0]   pos_q;
	logic [47:0]  hdr_q;
	logic         chained_q;
	logic [7:0]   body_q;
	logic         last_q;
	logic [5:0]   rnd_q;
	logic [31:0]  a_q, b_q, c_q, d_q;
	logic [511:0] blk_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == tbmpc_pkg::ST_IDLE);
	assign m_axis_tvalid = (state_q == tbmpc_pkg::ST_OUT);

	logic        s_acc;
	logic [47:0] hdr_n;
	logic        chain_n;
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign hdr_n   = s_axis_tuser ?
		{s_axis_tdata[31:0], s_axis_tdata[39:32], s_axis_tdata[47:40]} : hdr_q;
	assign chain_n = s_axis_tuser ? 1'b0 : chained_q;

	// build the padded message block, bytes in message order
	logic [5:0]   klen;
	logic [511:0] blk_n;
	always_comb begin
		logic [5:0] n;
		logic [6:0] total;
		klen = (key_len_q > 6'(tbmpc_pkg::MAX_KEY_BYTES)) ?
			6'(tbmpc_pkg::MAX_KEY_BYTES) : key_len_q;
		blk_n = '0;
		for (int i = 0; i < 4; i++)
			blk_n[8*i +: 8] = hdr_n[47-8*i -: 8];
		for (int i = 0; i < 32; i++)
			if (6'(i) < klen)
				blk_n[8*(4+i) +: 8] = key_q[255-8*i -: 8];
		n = 6'd4 + klen;
		blk_n[{n, 3'd0} +: 8] = hdr_n[15:8];
		blk_n[{n + 6'd1, 3'd0} +: 8] = hdr_n[7:0];
		n = n + 6'd2;
		if (chain_n) begin
			for (int i = 0; i < 16; i++)
				blk_n[{n + 6'(i), 3'd0} +: 8] = pad_q[127-8*i -: 8];
			n = n + 6'd16;
		end
		blk_n[{n, 3'd0} +: 8] = 8'h80;
		total = {1'b0, n};
		blk_n[448 +: 16] = {6'd0, total, 3'd0};
	end

	// shared round unit
	logic [31:0] f, mw, sum, rot;
	logic [3:0]  g;
	logic [4:0]  sh;
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = rnd_q[3:0]; end
			2'd1: begin f = (d_q & b_q) | (~d_q & c_q); g = 4'(5*rnd_q + 1); end
			2'd2: begin f = b_q ^ c_q ^ d_q;             g = 4'(3*rnd_q + 5); end
			default: begin f = c_q ^ (b_q | ~d_q);       g = 4'(7*rnd_q); end
		endcase
		mw  = blk_q[{g, 5'd0} +: 32];
		sh  = tbmpc_pkg::md5_s(rnd_q);
		sum = a_q + f + tbmpc_pkg::md5_k(rnd_q) + mw;
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	// digest bytes little endian per word, pad byte 0 most significant
	logic [127:0] dig;
	always_comb begin
		logic [31:0] h [4];
		h[0] = tbmpc_pkg::IV_A + a_q;
		h[1] = tbmpc_pkg::IV_B + b_q;
		h[2] = tbmpc_pkg::IV_C + c_q;
		h[3] = tbmpc_pkg::IV_D + d_q;
		for (int i = 0; i < 16; i++)
			dig[127-8*i -: 8] = h[i/4][8*(i%4) +: 8];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tbmpc_pkg::REG_KEY_LEN: key_len_q <= cfg_data[5:0];
				tbmpc_pkg::REG_KEY_0:   key_q[255:192] <= cfg_data;
				tbmpc_pkg::REG_KEY_1:   key_q[191:128] <= cfg_data;
				tbmpc_pkg::REG_KEY_2:   key_q[127:64]  <= cfg_data;
				tbmpc_pkg::REG_KEY_3:   key_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tbmpc_pkg::ST_IDLE;
			pad_q     <= '0;
			pos_q     <= '0;
			hdr_q     <= '0;
			chained_q <= 1'b0;
			body_q    <= '0;
			last_q    <= 1'b0;
			blk_q     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			c_q       <= '0;
			d_q       <= '0;
			rnd_q     <= '0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
		end else begin
			unique case (state_q)
				tbmpc_pkg::ST_IDLE: if (s_acc) begin
					body_q    <= s_axis_tdata[55:48];
					last_q    <= s_axis_tlast;
					hdr_q     <= hdr_n;
					chained_q <= chain_n;
					if (s_axis_tuser || pos_q == 4'd0) begin
						pos_q   <= '0;
						blk_q   <= blk_n;
						a_q <= tbmpc_pkg::IV_A; b_q <= tbmpc_pkg::IV_B;
						c_q <= tbmpc_pkg::IV_C; d_q <= tbmpc_pkg::IV_D;
						rnd_q   <= '0;
						state_q <= tbmpc_pkg::ST_ROUND;
					end else begin
						state_q <= tbmpc_pkg::ST_FINAL;
					end
				end
				tbmpc_pkg::ST_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= tbmpc_pkg::ST_FINAL;
						chained_q <= 1'b1;
					end
				end
				tbmpc_pkg::ST_FINAL: begin
					// a fresh pad is pending when the position is zero
					m_axis_tlast <= last_q;
					if (pos_q == 4'd0) begin
						pad_q <= dig;
						m_axis_tdata <= body_q ^ dig[127:120];
					end else begin
						m_axis_tdata <= body_q ^ pad_q[{~pos_q, 3'd0} +: 8];
					end
					pos_q   <= pos_q + 4'd1;
					state_q <= tbmpc_pkg::ST_OUT;
				end
				tbmpc_pkg::ST_OUT: if (m_axis_tready) state_q <= tbmpc_pkg::ST_IDLE;
				default: state_q <= tbmpc_pkg::ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
	a_round_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbmpc_pkg::ST_ROUND && rnd_q == 6'd63) |=>
		state_q == tbmpc_pkg::ST_FINAL) else $error("round count lost");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");

endmodule

/* test/tbmpc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tbmpc_checker
// Watches the cipher's channels, predicts each output byte with an
// independent MD5 pad chain, and counts mismatches.
// ----------------------------------------------------------------------------
module tbmpc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          bytes_seen
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_out_t;

	logic [5:0]   key_len;
	logic [63:0]  key_word [4];
	logic [127:0] pad;
	logic [3:0]   pad_pos;
	logic [47:0]  hdr;
	logic         chained;
	cipher_out_t  expected_bytes [$];

	localparam int SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
	localparam logic [31:0] RCONST [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
		32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
		32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
		32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
		32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
		32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

	// Build the next pad from the header, key and (when chained) the old pad.
	function automatic logic [127:0] next_pad(input logic [47:0] h, input logic [5:0] klen_reg,
			input logic [63:0] kw0, input logic [63:0] kw1, input logic [63:0] kw2,
			input logic [63:0] kw3, input logic chain, input logic [127:0] old_pad);
		logic [7:0]  blk [64];
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t, x;
		logic [255:0] keys;
		logic [127:0] dig;
		int n, klen, g;
		keys = {kw0, kw1, kw2, kw3};
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		klen = (klen_reg > tbmpc_pkg::MAX_KEY_BYTES) ? tbmpc_pkg::MAX_KEY_BYTES : klen_reg;
		n = 0;
		for (int i = 0; i < 4; i++) begin
			blk[n] = h[47 - 8*i -: 8];
			n++;
		end
		for (int i = 0; i < klen; i++) begin
			blk[n] = keys[255 - 8*i -: 8];
			n++;
		end
		blk[n] = h[15:8];
		blk[n+1] = h[7:0];
		n += 2;
		if (chain) begin
			for (int i = 0; i < 16; i++) blk[n+i] = old_pad[127 - 8*i -: 8];
			n += 16;
		end
		blk[n] = 8'h80;
		blk[56] = 8'(n * 8);
		blk[57] = 8'((n * 8) >> 8);
		for (int i = 0; i < 16; i++)
			m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5*i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3*i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7*i) % 16;
			end
			x = a + f + RCONST[i] + m[g];
			t = d; d = c; c = b;
			b = b + ((x << SHIFT[(i/16)*4 + i%4]) | (x >> (32 - SHIFT[(i/16)*4 + i%4])));
			a = t;
		end
		a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
		// digest bytes little endian per word, pad byte 0 most significant
		dig = {a[7:0], a[15:8], a[23:16], a[31:24], b[7:0], b[15:8], b[23:16], b[31:24],
			c[7:0], c[15:8], c[23:16], c[31:24], d[7:0], d[15:8], d[23:16], d[31:24]};
		return dig;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t exp_b, got;
		if (!arst_n) begin
			key_len = '0;
			for (int i = 0; i < 4; i++) key_word[i] = '0;
			pad = '0; pad_pos = '0; hdr = '0; chained = 1'b0;
			expected_bytes.delete();
			errors = 0;
			bytes_seen = 0;
			pending = 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tbmpc_pkg::REG_KEY_LEN: key_len = cfg_data[5:0];
					tbmpc_pkg::REG_KEY_0:   key_word[0] = cfg_data;
					tbmpc_pkg::REG_KEY_1:   key_word[1] = cfg_data;
					tbmpc_pkg::REG_KEY_2:   key_word[2] = cfg_data;
					tbmpc_pkg::REG_KEY_3:   key_word[3] = cfg_data;
					default: ;
				endcase
			end
			// compare the outgoing transaction with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got.data = m_axis_tdata;
				got.last = m_axis_tlast;
				bytes_seen++;
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected output byte %h last %b", $time, got.data, got.last);
					errors++;
				end else begin
					exp_b = expected_bytes.pop_front();
					if (exp_b.data !== got.data) begin
						$display("%0t: byte mismatch expected %h actual %h", $time,
							exp_b.data, got.data);
						errors++;
					end
					if (exp_b.last !== got.last) begin
						$display("%0t: last mismatch expected %b actual %b", $time,
							exp_b.last, got.last);
						errors++;
					end
				end
			end
			// predict the result of each incoming transaction
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					hdr = {s_axis_tdata[31:0], s_axis_tdata[39:32], s_axis_tdata[47:40]};
					pad_pos = '0;
					chained = 1'b0;
				end
				if (pad_pos == 0) begin
					pad = next_pad(hdr, key_len, key_word[0], key_word[1], key_word[2],
						key_word[3], chained, pad);
					chained = 1'b1;
				end
				exp_b.data = s_axis_tdata[55:48] ^ pad[127 - 8*pad_pos -: 8];
				exp_b.last = s_axis_tlast;
				expected_bytes.push_back(exp_b);
				pad_pos = pad_pos + 4'd1;
			end
			pending = expected_bytes.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives packets of body bytes under several keys through the pad cipher,
// with bursty input and a stalling output; the checker judges every byte.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;  // session_id, version, seq_no, body_byte
	logic        s_axis_tuser;  // first_byte
	logic        s_axis_tlast;  // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // result_byte
	logic        m_axis_tlast;  // result_last
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          errors;
	int          pending;
	int          bytes_seen;
	int          sent;
	int          idle_cycles;
	bit          hold_off;

	tacacs_body_md5_pad_cipher DUT (.*);

	tbmpc_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Send one byte; hold until accepted, then possibly gap.
	task automatic send_byte(input logic first, input logic [31:0] sid, input logic [7:0] ver,
			input logic [7:0] seq, input logic [7:0] body, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		s_axis_tdata  <= {body, seq, ver, sid};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// Random packet of the given length with random header.
	task automatic send_packet(input int len);
		logic [31:0] sid;
		logic [7:0]  ver, seq;
		sid = $urandom;
		ver = $urandom_range(0, 255);
		seq = $urandom_range(0, 255);
		for (int i = 0; i < len; i++)
			send_byte(i == 0, sid, ver, seq, $urandom_range(0, 255), i == len - 1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every prediction has drained, plus a pad computation.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic load_key(input logic [5:0] klen, input logic [63:0] k0,
			input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
		write_reg(tbmpc_pkg::REG_KEY_LEN, {58'd0, klen});
		write_reg(tbmpc_pkg::REG_KEY_0, k0);
		write_reg(tbmpc_pkg::REG_KEY_1, k1);
		write_reg(tbmpc_pkg::REG_KEY_2, k2);
		write_reg(tbmpc_pkg::REG_KEY_3, k3);
	endtask

	// Receiver: random stall pattern, plus a forced long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 9) < 7);
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tbmpc_pkg::REG_KEY_LEN;
		cfg_data = '0;
		sent = 0;
		hold_off = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset with no first byte: unchained pad from a zero header.
		send_byte(1'b0, 32'hffffffff, 8'hff, 8'hff, 8'h00, 1'b0);
		send_byte(1'b0, '0, '0, '0, 8'hff, 1'b1);
		// Continue the chain across a last byte, empty key.
		for (int i = 0; i < 16; i++)
			send_byte(1'b0, '0, '0, '0, 8'(i * 17), 1'b0);
		drain();

		// Full key, all ones, extreme header fields.
		load_key(6'd32, '1, '1, '1, '1);
		send_byte(1'b1, 32'hffffffff, 8'hff, 8'hff, 8'hff, 1'b1);
		send_byte(1'b1, 32'h00000000, 8'h00, 8'h00, 8'h00, 1'b0);
		// First byte inside a packet restarts the chain.
		send_byte(1'b0, '0, '0, '0, 8'h5a, 1'b0);
		send_byte(1'b1, 32'hc0011eaf, 8'hc1, 8'h01, 8'ha5, 1'b1);
		drain();

		// Over-long key length clamps; key with zero bytes; unknown indexes ignored.
		load_key(6'd63, 64'h0011002233004455, '0, 64'h8000000000000001, 64'h0123456789abcdef);
		write_reg(3'd5, '1);
		write_reg(3'd7, '1);
		send_packet(20);
		drain();

		// Random phase: a few key settings, mostly well-formed packets.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_key(6'd1, {$urandom, $urandom}, '0, '0, '0);
				1: load_key(6'd33, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
				default: load_key(6'($urandom_range(0, 32)), {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			endcase
			for (int p = 0; p < 10; p++) begin
				if ($urandom_range(0, 5) == 0) begin
					// stray bytes without a header
					repeat ($urandom_range(1, 5))
						send_byte(1'b0, $urandom, 8'($urandom), 8'($urandom),
							8'($urandom), 1'($urandom));
				end else begin
					send_packet($urandom_range(0, 3) == 0 ? $urandom_range(17, 40)
						: $urandom_range(1, 16));
				end
				// long receiver hold-off while the sender keeps offering
				if (phase == 2 && p == 1) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (400) @(negedge clk);
							hold_off = 1'b0;
						end
						send_packet(12);
					join
				end
			end
			drain();
		end

		$display("Sent %0d body bytes over %0d outputs under several key lengths (0, 1,",
			sent, bytes_seen);
		$display("  32 and clamped), with header restarts, stray bytes and output stalls.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
